/* sv/i2da_pkg.sv */
package i2da_pkg;

    localparam int NUM_DIGITS = 10;
    localparam int NUM_STAGES = NUM_DIGITS + 1;

    localparam logic [7:0] RADIX_DECIMAL = 8'd10;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_MINUS   = 8'h2D;
    localparam logic [7:0] ASCII_NUL     = 8'h00;

    typedef struct packed {
        logic                       ok;
        logic                       neg;
        logic [31:0]                mag;
        logic [NUM_DIGITS-1:0][3:0] digits;
    } i2da_item_t;

    typedef struct packed {
        logic [3:0]  digit;
        logic [31:0] rem;
    } i2da_step_t;

    // Digit 0 weighs 10^9, digit 9 is the units digit.
    function automatic logic [31:0] pow10(input logic [3:0] idx);
        logic [31:0] p;
        case (idx)
            4'd0:    p = 32'd1000000000;
            4'd1:    p = 32'd100000000;
            4'd2:    p = 32'd10000000;
            4'd3:    p = 32'd1000000;
            4'd4:    p = 32'd100000;
            4'd5:    p = 32'd10000;
            4'd6:    p = 32'd1000;
            4'd7:    p = 32'd100;
            4'd8:    p = 32'd10;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

    // The multiples of the power are constants per stage, so this is nine
    // compares against fixed values and a selected subtraction.
    function automatic i2da_step_t digit_step(input logic [31:0] mag,
                                              input logic [3:0]  idx);
        logic [35:0] mult;
        logic [35:0] wide;
        i2da_step_t  r;
        wide    = {4'd0, mag};
        r.digit = 4'd0;
        r.rem   = mag;
        for (int k = 1; k < 10; k++)
        begin
            mult = 36'(k) * {4'd0, pow10(idx)};
            if (wide >= mult)
            begin
                r.digit = 4'(k);
                r.rem   = 32'(wide - mult);
            end
        end
        return r;
    endfunction

endpackage

/* sv/i2da_pipe.sv */
module i2da_pipe (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         value,
    input  logic [7:0]          radix,
    output logic                out_valid,
    input  logic                out_ready,
    output i2da_pkg::i2da_item_t out_item
);
    import i2da_pkg::*;

    logic       [NUM_STAGES-1:0] vld_reg;
    i2da_item_t                  item_reg  [NUM_STAGES];
    i2da_item_t                  item_next [NUM_STAGES];
    logic       [NUM_STAGES-1:0] rdy;
    i2da_step_t                  step;

    always_comb
    begin
        rdy[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || out_ready;
        for (int s = NUM_STAGES - 2; s >= 0; s--)
        begin
            rdy[s] = !vld_reg[s] || rdy[s+1];
        end
    end

    always_comb
    begin
        item_next[0].ok     = (radix == RADIX_DECIMAL);
        item_next[0].neg    = value[31];
        item_next[0].mag    = value[31] ? (32'd0 - value) : value;
        item_next[0].digits = '0;
        step = '0;
        for (int s = 1; s < NUM_STAGES; s++)
        begin
            step = digit_step(item_reg[s-1].mag, 4'(s - 1));
            item_next[s] = item_reg[s-1];
            item_next[s].mag = step.rem;
            item_next[s].digits[s-1] = step.digit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int s = 1; s < NUM_STAGES; s++)
            begin
                if (rdy[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NUM_STAGES; s++)
        begin
            if (rdy[s])
            begin
                item_reg[s] <= item_next[s];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NUM_STAGES-1];
    assign out_item  = item_reg[NUM_STAGES-1];

endmodule

/* sv/int32_to_decimal_ascii_top.sv */
// Converts a signed 32-bit value to decimal ASCII text, one character per output word, ending
// with a NUL terminator flagged by last; a radix other than ten gives only the terminator. Each
// input word passes through an eleven-stage pipeline (an input stage and one stage per decimal
// digit) before the character sequencer takes it. The sequencer emits one character per cycle
// while out_ready is high, one to twelve per word, and takes the next word from the pipeline in
// the cycle its terminator leaves, so the sustained rate is set by the number of characters in
// each text. Up to eleven further words may be accepted while a text is still being emitted.
module int32_to_decimal_ascii_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] value,
    input  logic [7:0]  radix,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  char_code,
    output logic        last
);
    import i2da_pkg::*;

    localparam logic [1:0] ST_SIGN  = 2'd0;
    localparam logic [1:0] ST_DIGIT = 2'd1;
    localparam logic [1:0] ST_TERM  = 2'd2;

    logic       pipe_valid;
    logic       pipe_ready;
    i2da_item_t pipe_item;

    logic                       busy_reg;
    logic                       busy_next;
    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [3:0]                 idx_reg;
    logic [3:0]                 idx_next;
    logic [NUM_DIGITS-1:0][3:0] dig_reg;
    logic [3:0]                 first_idx;
    logic                       load;

    i2da_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .radix     (radix),
        .out_valid (pipe_valid),
        .out_ready (pipe_ready),
        .out_item  (pipe_item)
    );

    // A zero magnitude starts at the units digit, which gives the single '0'.
    always_comb
    begin
        first_idx = 4'(NUM_DIGITS - 1);
        for (int i = NUM_DIGITS - 1; i >= 0; i--)
        begin
            if (pipe_item.digits[i] != 4'd0)
            begin
                first_idx = 4'(i);
            end
        end
    end

    assign pipe_ready = !busy_reg || ((state_reg == ST_TERM) && out_ready);
    assign load       = pipe_valid && pipe_ready;

    always_comb
    begin
        busy_next  = busy_reg;
        state_next = state_reg;
        idx_next   = idx_reg;
        if (busy_reg && out_ready)
        begin
            case (state_reg)
                ST_SIGN:
                begin
                    state_next = ST_DIGIT;
                end
                ST_DIGIT:
                begin
                    if (idx_reg == 4'(NUM_DIGITS - 1))
                    begin
                        state_next = ST_TERM;
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = first_idx;
            if (!pipe_item.ok)
            begin
                state_next = ST_TERM;
            end
            else if (pipe_item.neg)
            begin
                state_next = ST_SIGN;
            end
            else
            begin
                state_next = ST_DIGIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            state_reg <= ST_TERM;
            idx_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dig_reg <= pipe_item.digits;
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_SIGN:  char_code = ASCII_MINUS;
            ST_DIGIT: char_code = ASCII_ZERO + {4'd0, dig_reg[idx_reg]};
            default:  char_code = ASCII_NUL;
        endcase
    end

    assign last      = (state_reg == ST_TERM);
    assign out_valid = busy_reg;

endmodule

/* tb/tb_top.sv */
module tb_top;
    import i2da_pkg::*;

    class text_scoreboard;
        typedef struct
        {
            logic [7:0] code;
            logic       last;
            int         word_idx;
        } char_t;

        char_t pending_chars[$];
        int    words_noted;
        int    chars_checked;
        int    mismatches;
        int    negatives;
        int    zeros;
        int    non_decimal;

        function void push_char(logic [7:0] code, logic last);
            char_t c;
            c.code     = code;
            c.last     = last;
            c.word_idx = words_noted;
            pending_chars.push_back(c);
        endfunction

        // Works out the decimal text of an accepted word, terminator included.
        function void note_word(logic [31:0] val, logic [7:0] rdx);
            logic [31:0] mag;
            logic [31:0] power;
            logic [31:0] digit;
            bit          started;
            started = 0;
            if (rdx != RADIX_DECIMAL)
            begin
                non_decimal++;
            end
            else if (val == 32'd0)
            begin
                zeros++;
                push_char(ASCII_ZERO, 1'b0);
            end
            else
            begin
                mag = val;
                if (val[31])
                begin
                    negatives++;
                    push_char(ASCII_MINUS, 1'b0);
                    mag = -val;
                end
                power = 32'd1000000000;
                for (int i = 0; i < 10; i++)
                begin
                    digit = mag / power;
                    if (digit != 0 || started)
                    begin
                        push_char(ASCII_ZERO + digit[7:0], 1'b0);
                        mag     = mag - digit * power;
                        started = 1;
                    end
                    power = power / 10;
                end
            end
            push_char(ASCII_NUL, 1'b1);
            words_noted++;
        endfunction

        function void check_char(logic [7:0] code, logic last);
            char_t want;
            if (pending_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected character 0x%02h last %0d with no word outstanding",
                             code, last);
            end
            else
            begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (want.code !== code || want.last !== last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Word %0d: expected char 0x%02h last %0d, got 0x%02h last %0d",
                                 want.word_idx, want.code, want.last, code, last);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] value;
    logic [7:0]  radix;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  char_code;
    logic        last;

    text_scoreboard sb = new();
    int             send_idle_pct;
    int             recv_idle_pct;
    int             hold_cycles;

    int32_to_decimal_ascii_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .radix     (radix),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_char(char_code, last);
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance, valid still high.
    task automatic send_word(input logic [31:0] val, input logic [7:0] rdx);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= val;
        radix    <= rdx;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_word(val, rdx);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_chars.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_phase(input int count, input int hold_at);
        logic [31:0] val;
        logic [7:0]  rdx;
        int          sel;
        int          ceiling;
        for (int n = 0; n < count; n++)
        begin
            if (n == hold_at)
                hold_cycles = 400;
            sel = $urandom_range(0, 4);
            case (sel)
                0: val = $urandom();
                1:
                begin
                    ceiling = 10 ** $urandom_range(1, 9) - 1;
                    val     = $urandom_range(0, ceiling);
                end
                2: val = $urandom_range(0, 12);
                3: val = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 2)
                                              : 32'h7FFF_FFFF - $urandom_range(0, 2);
                default: val = 10 ** $urandom_range(0, 9) + $urandom_range(0, 2) - 1;
            endcase
            if (sel != 0 && sel != 3 && $urandom_range(0, 1))
                val = -val;
            rdx = ($urandom_range(0, 99) < 85) ? RADIX_DECIMAL : 8'($urandom_range(0, 255));
            send_word(val, rdx);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        value         = 32'd0;
        radix         = 8'd0;
        hold_cycles   = 0;
        send_idle_pct = 26;
        recv_idle_pct = 70;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_word(32'd0, RADIX_DECIMAL);
        send_word(32'd1, RADIX_DECIMAL);
        send_word(-32'sd1, RADIX_DECIMAL);
        send_word(32'd9, RADIX_DECIMAL);
        send_word(32'd10, RADIX_DECIMAL);
        send_word(32'd100, RADIX_DECIMAL);
        send_word(32'h7FFF_FFFF, RADIX_DECIMAL);
        send_word(32'h8000_0000, RADIX_DECIMAL);
        send_word(32'h8000_0001, RADIX_DECIMAL);
        send_word(32'd1000000000, RADIX_DECIMAL);
        send_word(32'd999999999, RADIX_DECIMAL);
        send_word(-32'sd1000000000, RADIX_DECIMAL);
        send_word(32'd1234567890, RADIX_DECIMAL);
        send_word(-32'sd987654321, RADIX_DECIMAL);
        send_word(32'hAAAA_AAAA, RADIX_DECIMAL);
        send_word(32'h5555_5555, RADIX_DECIMAL);
        send_word(32'd0, 8'd0);
        send_word(32'd5, 8'd255);
        send_word(32'd77, 8'd11);
        send_word(32'd77, 8'd9);
        send_word(32'h8000_0000, 8'd16);
        send_word(32'hFFFF_FFFF, 8'hAA);
        send_word(32'd42, 8'h55);
        drain();

        random_phase(55, -1);
        drain();

        send_idle_pct = 70;
        recv_idle_pct = 26;
        random_phase(55, -1);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(55, 10);
        drain();

        repeat (30) @(posedge clk);

        $display("Covered %0d words and %0d characters: %0d negative, %0d zero, %0d other radix.",
                 sb.words_noted, sb.chars_checked, sb.negatives, sb.zeros, sb.non_decimal);
        if (sb.mismatches > 10)
            $display("%0d mismatches in total.", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_chars.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* filelist.f */
sv/i2da_pkg.sv
sv/i2da_pipe.sv
sv/int32_to_decimal_ascii_top.sv
tb/tb_top.sv
